[src/cpcr_pkg.sv]
// Shared constants, types and saturation helpers for the circle pair collision block.
package cpcr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int RESTI_W   = 17;
  localparam int GAIN_W    = RESTI_W + 1;
  localparam int GM_W      = GAIN_W + 32;
  localparam int MSUM_W    = 33;
  // Bound on the impulse quotient: dot < 2^63 and dist2 >= about 2^(2F)/1000.
  localparam int J_W       = 73 - FRAC_BITS;
  localparam int S_W       = GAIN_W;
  localparam int DIV_STAGES = J_W;
  localparam int PIPE_LATENCY = 4 + DIV_STAGES + 5;

  localparam logic [RESTI_W-1:0] RESTI_ONE = RESTI_W'(65536);
  localparam logic [63:0] COINCIDE_LIMIT =
    ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000 + 64'd1;

  typedef enum logic [1:0] {
    OUT_NONE       = 2'd0,
    OUT_SEPARATING = 2'd1,
    OUT_APPLIED    = 2'd2
  } outcome_t;

  typedef struct packed {
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    outcome_t           code;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
    logic signed [63:0] r;
    if (v[64] != v[63]) r = v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else r = v[63:0];
    return r;
  endfunction

endpackage

[src/cpcr_div_pipe.sv]
// Pipelined restoring dividers: impulse quotient and the two mass gain ratios.
module cpcr_div_pipe
  import cpcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [62:0]       in_dot,
  input  logic [63:0]       in_dist2,
  input  logic [GM_W-1:0]   in_gm1,
  input  logic [GM_W-1:0]   in_gm2,
  input  logic [MSUM_W-1:0] in_msum,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [J_W-1:0]    out_j,
  output logic [S_W-1:0]    out_s1,
  output logic [S_W-1:0]    out_s2,
  output side_t             out_side
);

  logic              vld [0:DIV_STAGES];
  logic [63:0]       jr  [0:DIV_STAGES];
  logic [J_W-1:0]    jq  [0:DIV_STAGES];
  logic [J_W-1:0]    jn  [0:DIV_STAGES];
  logic [63:0]       dv  [0:DIV_STAGES];
  logic [MSUM_W-1:0] ar  [0:DIV_STAGES];
  logic [MSUM_W-1:0] br  [0:DIV_STAGES];
  logic [S_W-1:0]    aq  [0:DIV_STAGES];
  logic [S_W-1:0]    bq  [0:DIV_STAGES];
  logic [S_W-1:0]    an  [0:DIV_STAGES];
  logic [S_W-1:0]    bn  [0:DIV_STAGES];
  logic [MSUM_W-1:0] md  [0:DIV_STAGES];
  side_t             sd  [0:DIV_STAGES];

  // The top bits of each dividend are already below the divisor.
  assign vld[0] = in_valid;
  assign jr[0]  = 64'(in_dot >> (J_W - FRAC_BITS));
  assign jq[0]  = '0;
  assign jn[0]  = {in_dot[J_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign dv[0]  = in_dist2;
  assign ar[0]  = MSUM_W'(in_gm1 >> S_W);
  assign br[0]  = MSUM_W'(in_gm2 >> S_W);
  assign aq[0]  = '0;
  assign bq[0]  = '0;
  assign an[0]  = in_gm1[S_W-1:0];
  assign bn[0]  = in_gm2[S_W-1:0];
  assign md[0]  = in_msum;
  assign sd[0]  = in_side;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [64:0] j_sh;
    logic        j_ge;
    assign j_sh = {jr[k], jn[k][J_W-1]};
    assign j_ge = j_sh >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      jr[k+1] <= j_ge ? 64'(j_sh - {1'b0, dv[k]}) : j_sh[63:0];
      jq[k+1] <= {jq[k][J_W-2:0], j_ge};
      jn[k+1] <= jn[k] << 1;
      dv[k+1] <= dv[k];
      md[k+1] <= md[k];
      sd[k+1] <= sd[k];
    end

    if (k < S_W) begin : g_gain
      logic [MSUM_W:0] a_sh, b_sh;
      logic            a_ge, b_ge;
      assign a_sh = {ar[k], an[k][S_W-1]};
      assign b_sh = {br[k], bn[k][S_W-1]};
      assign a_ge = a_sh >= {1'b0, md[k]};
      assign b_ge = b_sh >= {1'b0, md[k]};

      always_ff @(posedge clk) begin
        ar[k+1] <= a_ge ? MSUM_W'(a_sh - {1'b0, md[k]}) : a_sh[MSUM_W-1:0];
        br[k+1] <= b_ge ? MSUM_W'(b_sh - {1'b0, md[k]}) : b_sh[MSUM_W-1:0];
        aq[k+1] <= {aq[k][S_W-2:0], a_ge};
        bq[k+1] <= {bq[k][S_W-2:0], b_ge};
        an[k+1] <= an[k] << 1;
        bn[k+1] <= bn[k] << 1;
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        ar[k+1] <= ar[k];
        br[k+1] <= br[k];
        aq[k+1] <= aq[k];
        bq[k+1] <= bq[k];
        an[k+1] <= an[k];
        bn[k+1] <= bn[k];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign out_j     = jq[DIV_STAGES];
  assign out_s1    = aq[DIV_STAGES];
  assign out_s2    = bq[DIV_STAGES];
  assign out_side  = sd[DIV_STAGES];

endmodule

[src/circle_pair_collision_response.sv]
// Top level: two-circle contact test and restitution velocity update, fully pipelined.
//
// Usage: drive the twelve circle fields and raise start; a beat is taken at every
// clock edge with start high and busy low. busy is high only during reset, so a
// new pair can enter every cycle. Each pair yields exactly one result beat:
// done is high for one cycle with the four new velocities and outcome on the
// result ports; throughput is one pair per cycle. The impulse divider
// resolves one quotient bit per stage over 57 stages; the contact test takes
// four stages before it and the impulse multiplies take five after it. The
// receiver cannot stall; results leave on schedule. Reset (rst, synchronous)
// empties the pipeline, dropping pairs in flight, and sets restitution to
// fully elastic. Write cfg_wr_data with cfg_wr_en only while no pair is in
// flight.
module circle_pair_collision_response
  import cpcr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cfg_wr_en,
  input  logic [RESTI_W-1:0]       cfg_wr_data,
  input  logic signed [31:0]       first_pos_x,
  input  logic signed [31:0]       first_pos_y,
  input  logic signed [31:0]       first_vel_x,
  input  logic signed [31:0]       first_vel_y,
  input  logic [31:0]              first_radius,
  input  logic [31:0]              first_mass,
  input  logic signed [31:0]       second_pos_x,
  input  logic signed [31:0]       second_pos_y,
  input  logic signed [31:0]       second_vel_x,
  input  logic signed [31:0]       second_vel_y,
  input  logic [31:0]              second_radius,
  input  logic [31:0]              second_mass,
  output logic                     done,
  output logic signed [31:0]       new_first_vel_x,
  output logic signed [31:0]       new_first_vel_y,
  output logic signed [31:0]       new_second_vel_x,
  output logic signed [31:0]       new_second_vel_y,
  output logic [1:0]               outcome
);

  logic [RESTI_W-1:0] restitution;
  logic [GAIN_W-1:0]  gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= RESTI_ONE;
    end else if (cfg_wr_en) begin
      restitution <= cfg_wr_data;
    end
  end

  assign busy = rst;
  assign gain = GAIN_W'(RESTI_ONE) + GAIN_W'(restitution);

  // Stage 1: offsets, relative velocity, radius sum, mass products
  logic               p1_valid;
  side_t              p1_side;
  logic signed [31:0] p1_rvx, p1_rvy;
  logic [32:0]        p1_rs;
  logic [GM_W-1:0]    p1_gm1, p1_gm2;
  logic [MSUM_W-1:0]  p1_msum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= start && !busy;
    end
    p1_side.v1x  <= first_vel_x;
    p1_side.v1y  <= first_vel_y;
    p1_side.v2x  <= second_vel_x;
    p1_side.v2y  <= second_vel_y;
    p1_side.dx   <= sat32(50'(second_pos_x) - 50'(first_pos_x));
    p1_side.dy   <= sat32(50'(second_pos_y) - 50'(first_pos_y));
    p1_side.code <= OUT_NONE;
    p1_rvx  <= sat32(50'(first_vel_x) - 50'(second_vel_x));
    p1_rvy  <= sat32(50'(first_vel_y) - 50'(second_vel_y));
    p1_rs   <= 33'(first_radius) + 33'(second_radius);
    // the first circle's share scales with the other circle's mass
    p1_gm1  <= gain * second_mass;
    p1_gm2  <= gain * first_mass;
    p1_msum <= 33'(first_mass) + 33'(second_mass);
  end

  // Stage 2: squares and dot-product terms
  logic               p2_valid;
  side_t              p2_side;
  logic signed [63:0] p2_dx2, p2_dy2, p2_pdx, p2_pdy;
  logic [63:0]        p2_rs2;
  logic [GM_W-1:0]    p2_gm1, p2_gm2;
  logic [MSUM_W-1:0]  p2_msum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_side <= p1_side;
    p2_dx2  <= p1_side.dx * p1_side.dx;
    p2_dy2  <= p1_side.dy * p1_side.dy;
    p2_pdx  <= p1_rvx * p1_side.dx;
    p2_pdy  <= p1_rvy * p1_side.dy;
    p2_rs2  <= p1_rs[32] ? '1 : p1_rs[31:0] * p1_rs[31:0];
    p2_gm1  <= p1_gm1;
    p2_gm2  <= p1_gm2;
    p2_msum <= p1_msum;
  end

  // Stage 3: squared distance and saturated dot product
  logic               p3_valid;
  side_t              p3_side;
  logic [63:0]        p3_dist2, p3_rs2;
  logic signed [63:0] p3_dot;
  logic [GM_W-1:0]    p3_gm1, p3_gm2;
  logic [MSUM_W-1:0]  p3_msum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_side  <= p2_side;
    p3_dist2 <= unsigned'(p2_dx2) + unsigned'(p2_dy2);
    p3_rs2   <= p2_rs2;
    p3_dot   <= sat64(65'(p2_pdx) + 65'(p2_pdy));
    p3_gm1   <= p2_gm1;
    p3_gm2   <= p2_gm2;
    p3_msum  <= p2_msum;
  end

  // Stage 4: classify the pair, prepare divider operands
  logic              p4_valid;
  side_t             p4_side;
  logic [62:0]       p4_dot;
  logic [63:0]       p4_dist2;
  logic [GM_W-1:0]   p4_gm1, p4_gm2;
  logic [MSUM_W-1:0] p4_msum;
  logic              contact, approaching, no_mass;
  outcome_t          code_next;
  side_t             p4_side_next;

  assign contact    = (p3_dist2 <= p3_rs2) && (p3_dist2 >= COINCIDE_LIMIT);
  assign approaching = p3_dot > 64'sd0;
  assign no_mass    = p3_msum == '0;

  always_comb begin
    code_next = OUT_NONE;
    if (contact) begin
      code_next = approaching ? OUT_APPLIED : OUT_SEPARATING;
    end
    p4_side_next = p3_side;
    p4_side_next.code = code_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
    end
    p4_side      <= p4_side_next;
    p4_dot       <= p3_dot[62:0];
    p4_dist2     <= p3_dist2;
    // zero total mass: force both gain ratios to zero
    p4_gm1  <= no_mass ? '0 : p3_gm1;
    p4_gm2  <= no_mass ? '0 : p3_gm2;
    p4_msum <= no_mass ? MSUM_W'(1) : p3_msum;
  end

  logic           d_valid;
  logic [J_W-1:0] d_j;
  logic [S_W-1:0] d_s1, d_s2;
  side_t          d_side;

  cpcr_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p4_valid),
    .in_dot   (p4_dot),
    .in_dist2 (p4_dist2),
    .in_gm1   (p4_gm1),
    .in_gm2   (p4_gm2),
    .in_msum  (p4_msum),
    .in_side  (p4_side),
    .out_valid(d_valid),
    .out_j    (d_j),
    .out_s1   (d_s1),
    .out_s2   (d_s2),
    .out_side (d_side)
  );

  // M1: |d| times impulse, split into partial products
  logic [31:0] ax, ay;
  assign ax = d_side.dx[31] ? 32'(-d_side.dx) : 32'(d_side.dx);
  assign ay = d_side.dy[31] ? 32'(-d_side.dy) : 32'(d_side.dy);

  logic              m1_valid;
  side_t             m1_side;
  logic [S_W-1:0]    m1_s1, m1_s2;
  logic [63:0]       m1_xlo, m1_ylo;
  logic [J_W-1:0]    m1_xhi, m1_yhi;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= d_valid;
    end
    m1_side <= d_side;
    m1_s1   <= d_s1;
    m1_s2   <= d_s2;
    m1_xlo  <= ax * d_j[31:0];
    m1_ylo  <= ay * d_j[31:0];
    m1_xhi  <= ax * d_j[J_W-1:32];
    m1_yhi  <= ay * d_j[J_W-1:32];
  end

  // M2: combine, saturate to 64 bits, drop fraction
  logic [J_W+31:0] wxf, wyf;
  assign wxf = (J_W+32)'(m1_xlo) + ((J_W+32)'(m1_xhi) << 32);
  assign wyf = (J_W+32)'(m1_ylo) + ((J_W+32)'(m1_yhi) << 32);

  logic           m2_valid;
  side_t          m2_side;
  logic [S_W-1:0] m2_s1, m2_s2;
  logic [47:0]    m2_wx, m2_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
    m2_side <= m1_side;
    m2_s1   <= m1_s1;
    m2_s2   <= m1_s2;
    m2_wx   <= (|wxf[J_W+31:64]) ? '1 : wxf[63:16];
    m2_wy   <= (|wyf[J_W+31:64]) ? '1 : wyf[63:16];
  end

  // M3: impulse times gain ratios, partial products
  logic            m3_valid;
  side_t           m3_side;
  logic [S_W+31:0] m3_lo [0:3];
  logic [S_W+15:0] m3_hi [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else begin
      m3_valid <= m2_valid;
    end
    m3_side  <= m2_side;
    m3_lo[0] <= m2_wx[31:0] * m2_s1;
    m3_hi[0] <= m2_wx[47:32] * m2_s1;
    m3_lo[1] <= m2_wy[31:0] * m2_s1;
    m3_hi[1] <= m2_wy[47:32] * m2_s1;
    m3_lo[2] <= m2_wx[31:0] * m2_s2;
    m3_hi[2] <= m2_wx[47:32] * m2_s2;
    m3_lo[3] <= m2_wy[31:0] * m2_s2;
    m3_hi[3] <= m2_wy[47:32] * m2_s2;
  end

  // M4: combine, saturate, drop Q.16 fraction
  logic        m4_valid;
  side_t       m4_side;
  logic [47:0] m4_t [0:3];

  for (genvar i = 0; i < 4; i++) begin : g_comb
    logic [S_W+47:0] tf;
    assign tf = (S_W+48)'(m3_lo[i]) + ((S_W+48)'(m3_hi[i]) << 32);
    always_ff @(posedge clk) begin
      m4_t[i] <= (|tf[S_W+47:64]) ? '1 : tf[63:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_valid <= 1'b0;
    end else begin
      m4_valid <= m3_valid;
    end
    m4_side <= m3_side;
  end

  // M5: apply the signed updates or pass the velocities through
  logic signed [49:0] dlx1, dly1, dlx2, dly2;
  logic               apply;
  assign dlx1 = m4_side.dx[31] ? -$signed({2'b0, m4_t[0]}) : $signed({2'b0, m4_t[0]});
  assign dly1 = m4_side.dy[31] ? -$signed({2'b0, m4_t[1]}) : $signed({2'b0, m4_t[1]});
  assign dlx2 = m4_side.dx[31] ? -$signed({2'b0, m4_t[2]}) : $signed({2'b0, m4_t[2]});
  assign dly2 = m4_side.dy[31] ? -$signed({2'b0, m4_t[3]}) : $signed({2'b0, m4_t[3]});
  assign apply = m4_side.code == OUT_APPLIED;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m4_valid;
    end
    new_first_vel_x  <= apply ? sat32(50'(m4_side.v1x) - dlx1) : m4_side.v1x;
    new_first_vel_y  <= apply ? sat32(50'(m4_side.v1y) - dly1) : m4_side.v1y;
    new_second_vel_x <= apply ? sat32(50'(m4_side.v2x) + dlx2) : m4_side.v2x;
    new_second_vel_y <= apply ? sat32(50'(m4_side.v2y) + dly2) : m4_side.v2y;
    outcome          <= m4_side.code;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##PIPE_LATENCY done)
    else $error("accepted beat did not come out on schedule");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##PIPE_LATENCY !done)
    else $error("result beat with no matching input beat");

  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    done && outcome != OUT_APPLIED |->
      new_first_vel_x == $past(first_vel_x, PIPE_LATENCY) &&
      new_second_vel_y == $past(second_vel_y, PIPE_LATENCY))
    else $error("velocities altered without a collision");

  a_apply_cond: assert property (@(posedge clk) disable iff (rst)
    p4_valid && p4_side.code == OUT_APPLIED |->
      $past(p3_dot) > 64'sd0 && p4_dist2 >= COINCIDE_LIMIT)
    else $error("collision applied without approach or with coincident centres");

endmodule
